// ===== src/pooled_linked_list_engine_unit_assert.svh =====
// assertion macros used by the engine unit
`ifndef POOLED_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH
`define POOLED_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PLLE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("engine assertion failed");

// antecedent implies consequent in the next cycle
`define PLLE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("engine assertion failed");

`endif

// ===== src/plle_pkg.sv =====
`default_nettype none
package plle_pkg;

    localparam int IDX_W      = 6;
    localparam int VAL_W      = 32;
    localparam int POOL_DEPTH = 64;

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [1:0]              mode_t;
    typedef logic [1:0]              status_t;

    localparam mode_t MODE_INSERT   = 2'd0;
    localparam mode_t MODE_DELETE   = 2'd1;
    localparam mode_t MODE_TRAVERSE = 2'd2;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_OVERFLOW  = 2'd1;
    localparam status_t STATUS_NOT_FOUND = 2'd2;
    localparam status_t STATUS_EMPTY     = 2'd3;

    // one request to the link store per cycle, with a read port and a write port
    typedef struct packed {
        logic rd_en;
        idx_t rd_addr;
        logic wr_en;
        idx_t wr_addr;
        idx_t wr_data;
    } link_req_t;

endpackage
`default_nettype wire

// ===== src/plle_ram.sv =====
`default_nettype none
module plle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/plle_link_store.sv =====
`default_nettype none
module plle_link_store #(
    parameter int NODE_COUNT = 63
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  plle_pkg::link_req_t   req,
    output plle_pkg::idx_t        rd_data
);
    import plle_pkg::*;

    logic [POOL_DEPTH-1:0] written_reg;
    logic                  rd_written_reg;
    idx_t                  rd_addr_reg;
    idx_t                  ram_q;

    // free chain at reset: i -> i+1 up to the last node, which ends it
    function automatic idx_t reset_link(idx_t a);
        idx_t r;
        r = '0;
        if (a != '0 && a < IDX_W'(NODE_COUNT)) begin
            r = a + idx_t'(1);
        end
        return r;
    endfunction

    plle_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (req.wr_en) begin
            written_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_written_reg <= written_reg[req.rd_addr];
            rd_addr_reg    <= req.rd_addr;
        end
    end

    assign rd_data = rd_written_reg ? ram_q : reset_link(rd_addr_reg);

endmodule
`default_nettype wire

// ===== src/pooled_linked_list_engine_unit.sv =====
`default_nettype none
// channel   direction  ports                                      handshake
// s_        in         s_mode, s_search_key, s_new_value          s_valid / s_ready
// m_        out        m_item_value, m_status, m_last             m_valid / m_ready
//
// one item at a time; a node visit is a WALK state (registered read of value and link
// memories) then a CHECK state (compare); a walk off the tail ends in a further WALK;
// insert passes FREE, FETCH and, on a match, INS_LINK (free-chain fetch, link writes);
// delete DEL_FREE and, off the head, DEL_LINK; traverse gives one transaction per node
// reset is instant: per-entry written bits stand in for the initial free chain
// a held transaction stalls the next result of any mode; the next item is taken
`include "pooled_linked_list_engine_unit_assert.svh"
module pooled_linked_list_engine_unit #(
    parameter int NODE_COUNT = 63
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  plle_pkg::mode_t    s_mode,
    input  plle_pkg::val_t     s_search_key,
    input  plle_pkg::val_t     s_new_value,
    output logic               m_valid,
    input  logic               m_ready,
    output plle_pkg::val_t     m_item_value,
    output plle_pkg::status_t  m_status,
    output logic               m_last
);
    import plle_pkg::*;

    localparam logic [3:0] STATE_IDLE     = 4'd0;
    localparam logic [3:0] STATE_WALK     = 4'd1;
    localparam logic [3:0] STATE_CHECK    = 4'd2;
    localparam logic [3:0] STATE_FREE     = 4'd3;
    localparam logic [3:0] STATE_FETCH    = 4'd4;
    localparam logic [3:0] STATE_INS_LINK = 4'd5;
    localparam logic [3:0] STATE_DEL_FREE = 4'd6;
    localparam logic [3:0] STATE_DEL_LINK = 4'd7;
    localparam logic [3:0] STATE_RESULT   = 4'd8;

    localparam idx_t STEP_MAX  = IDX_W'(NODE_COUNT);
    localparam idx_t STEP_LAST = IDX_W'(NODE_COUNT - 1);

    logic [3:0] state_reg;
    mode_t      mode_reg;
    val_t       key_reg;
    val_t       newval_reg;
    idx_t       p_reg;
    idx_t       prev_reg;
    idx_t       at_reg;
    idx_t       atnext_reg;
    idx_t       steps_reg;
    idx_t       head_reg;
    idx_t       free_reg;
    status_t    status_reg;

    logic       out_valid_reg;
    val_t       out_value_reg;
    status_t    out_status_reg;
    logic       out_last_reg;

    link_req_t  link_req;
    idx_t       link_q;
    logic       val_re;
    logic       val_we;
    val_t       val_q;

    logic       walk_done;
    logic       hit;
    logic       fin;
    logic       slot_free;
    logic       out_load;
    logic       err_result;
    logic       unused_take;

    assign walk_done = (p_reg == '0) || (steps_reg == STEP_MAX);
    assign hit       = (val_q == key_reg);
    assign fin       = (link_q == '0) || (steps_reg == STEP_LAST);
    assign slot_free = !out_valid_reg || m_ready;
    assign out_load  = slot_free && ((state_reg == STATE_RESULT) ||
                       ((state_reg == STATE_CHECK) && (mode_reg == MODE_TRAVERSE)));

    plle_ram #(
        .WIDTH (VAL_W),
        .DEPTH (POOL_DEPTH)
    ) u_value_ram (
        .aclk    (aclk),
        .wr_en   (val_we),
        .wr_addr (free_reg),
        .wr_data (newval_reg),
        .rd_en   (val_re),
        .rd_addr (p_reg),
        .rd_data (val_q)
    );

    plle_link_store #(
        .NODE_COUNT (NODE_COUNT)
    ) u_link_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (link_req),
        .rd_data (link_q)
    );

    always_comb begin
        link_req = '0;
        val_re   = 1'b0;
        val_we   = 1'b0;
        case (state_reg)
            STATE_WALK: begin
                if (!walk_done) begin
                    link_req.rd_en   = 1'b1;
                    link_req.rd_addr = p_reg;
                    val_re           = 1'b1;
                end
            end
            STATE_FREE: begin
                if (free_reg != '0) begin
                    link_req.rd_en   = 1'b1;
                    link_req.rd_addr = free_reg;
                end
            end
            STATE_FETCH: begin
                // new node links to the successor of the match, or to the old head
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = free_reg;
                link_req.wr_data = (at_reg != '0) ? atnext_reg : head_reg;
                val_we           = 1'b1;
            end
            STATE_INS_LINK: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = at_reg;
                link_req.wr_data = p_reg;
            end
            STATE_DEL_FREE: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = p_reg;
                link_req.wr_data = free_reg;
            end
            STATE_DEL_LINK: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = prev_reg;
                link_req.wr_data = atnext_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_IDLE;
            head_reg      <= '0;
            free_reg      <= idx_t'(1);
            steps_reg     <= '0;
        end else begin
            case (state_reg)
                STATE_IDLE: begin
                    if (s_valid) begin
                        mode_reg   <= s_mode;
                        key_reg    <= s_search_key;
                        newval_reg <= s_new_value;
                        p_reg      <= head_reg;
                        prev_reg   <= '0;
                        at_reg     <= '0;
                        steps_reg  <= '0;
                        case (s_mode)
                            MODE_INSERT, MODE_DELETE: begin
                                state_reg <= STATE_WALK;
                            end
                            MODE_TRAVERSE: begin
                                if (head_reg == '0) begin
                                    status_reg <= STATUS_EMPTY;
                                    state_reg  <= STATE_RESULT;
                                end else begin
                                    state_reg <= STATE_WALK;
                                end
                            end
                            default: begin
                                state_reg <= STATE_IDLE;
                            end
                        endcase
                    end
                end
                STATE_WALK: begin
                    if (walk_done) begin
                        if (mode_reg == MODE_INSERT) begin
                            state_reg <= STATE_FREE;
                        end else begin
                            status_reg <= STATUS_NOT_FOUND;
                            state_reg  <= STATE_RESULT;
                        end
                    end else begin
                        state_reg <= STATE_CHECK;
                    end
                end
                STATE_CHECK: begin
                    case (mode_reg)
                        MODE_INSERT: begin
                            if (hit) begin
                                at_reg     <= p_reg;
                                atnext_reg <= link_q;
                                state_reg  <= STATE_FREE;
                            end else begin
                                p_reg     <= link_q;
                                steps_reg <= steps_reg + idx_t'(1);
                                state_reg <= STATE_WALK;
                            end
                        end
                        MODE_DELETE: begin
                            if (hit) begin
                                atnext_reg <= link_q;
                                state_reg  <= STATE_DEL_FREE;
                            end else begin
                                prev_reg  <= p_reg;
                                p_reg     <= link_q;
                                steps_reg <= steps_reg + idx_t'(1);
                                state_reg <= STATE_WALK;
                            end
                        end
                        default: begin
                            // read data holds while waiting for the output slot
                            if (slot_free) begin
                                out_value_reg  <= val_q;
                                out_status_reg <= STATUS_OK;
                                out_last_reg   <= fin;
                                if (fin) begin
                                    state_reg <= STATE_IDLE;
                                end else begin
                                    p_reg     <= link_q;
                                    steps_reg <= steps_reg + idx_t'(1);
                                    state_reg <= STATE_WALK;
                                end
                            end
                        end
                    endcase
                end
                STATE_FREE: begin
                    if (free_reg == '0) begin
                        status_reg <= STATUS_OVERFLOW;
                        state_reg  <= STATE_RESULT;
                    end else begin
                        state_reg <= STATE_FETCH;
                    end
                end
                STATE_FETCH: begin
                    free_reg <= link_q;
                    p_reg    <= free_reg;
                    if (at_reg == '0) begin
                        head_reg   <= free_reg;
                        status_reg <= STATUS_OK;
                        state_reg  <= STATE_RESULT;
                    end else begin
                        state_reg <= STATE_INS_LINK;
                    end
                end
                STATE_INS_LINK: begin
                    status_reg <= STATUS_OK;
                    state_reg  <= STATE_RESULT;
                end
                STATE_DEL_FREE: begin
                    free_reg <= p_reg;
                    if (prev_reg == '0) begin
                        head_reg   <= atnext_reg;
                        status_reg <= STATUS_OK;
                        state_reg  <= STATE_RESULT;
                    end else begin
                        state_reg <= STATE_DEL_LINK;
                    end
                end
                STATE_DEL_LINK: begin
                    status_reg <= STATUS_OK;
                    state_reg  <= STATE_RESULT;
                end
                STATE_RESULT: begin
                    if (slot_free) begin
                        out_value_reg  <= '0;
                        out_status_reg <= status_reg;
                        out_last_reg   <= 1'b1;
                        state_reg      <= STATE_IDLE;
                    end
                end
                default: begin
                    state_reg <= STATE_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == STATE_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_item_value = out_value_reg;
    assign m_status     = out_status_reg;
    assign m_last       = out_last_reg;

    assign err_result  = m_valid && (m_status != STATUS_OK);
    assign unused_take = s_valid && s_ready && (s_mode != MODE_INSERT)
                         && (s_mode != MODE_DELETE) && (s_mode != MODE_TRAVERSE);

    // the pool can never be both fully used and empty
    `PLLE_ASSERT_NOW(a_pool_consistent, aclk, aresetn, 1'b1, (head_reg != '0) || (free_reg != '0))
    // a status other than ok is always a single transaction with a zero value
    `PLLE_ASSERT_NOW(a_status_result, aclk, aresetn, err_result, m_last && (m_item_value == '0))
    // an unused mode is dropped at once
    `PLLE_ASSERT_NEXT(a_unused_mode, aclk, aresetn, unused_take, s_ready)
    // walks stay bounded by the pool size
    `PLLE_ASSERT_NOW(a_walk_bound, aclk, aresetn, 1'b1, steps_reg <= STEP_MAX)

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import plle_pkg::*;

    localparam int    NODE_COUNT    = 63;
    localparam mode_t MODE_UNUSED   = 2'd3;
    localparam int    HOLD_CYCLES   = 300;
    localparam int    TAIL_CYCLES   = 300;
    localparam int    CYCLE_LIMIT   = 1_500_000;
    localparam int    CHURN_ITEMS   = 25;
    localparam int    FILL_ITEM_CAP = 150;

    localparam val_t VAL_MAX  = 32'sh7fff_ffff;
    localparam val_t VAL_MIN  = 32'sh8000_0000;
    localparam val_t VAL_ONES = -32'sd1;
    localparam val_t VAL_ZERO = 32'sd0;

    typedef struct {
        val_t    item_value;
        status_t status;
        logic    last;
    } list_result_t;

    class list_scoreboard;
        val_t         node_value[POOL_DEPTH];
        idx_t         next_index[POOL_DEPTH];
        idx_t         list_head;
        idx_t         free_head;
        list_result_t expected_results[$];
        int           mismatches;

        function new();
            for (int i = 0; i < POOL_DEPTH; i++) begin
                node_value[i] = '0;
                next_index[i] = '0;
            end
            // free chain runs 1 -> 2 -> ... -> NODE_COUNT -> null
            for (int i = 1; i < NODE_COUNT; i++) begin
                next_index[i] = idx_t'(i + 1);
            end
            next_index[NODE_COUNT] = '0;
            list_head  = '0;
            free_head  = idx_t'(1);
            mismatches = 0;
        endfunction

        function bit pool_full();
            return free_head == 0;
        endfunction

        function int list_length();
            idx_t p = list_head;
            int   n = 0;
            while (p != 0 && n < NODE_COUNT) begin
                p = next_index[p];
                n++;
            end
            return n;
        endfunction

        function val_t value_at(int k);
            idx_t p = list_head;
            for (int i = 0; i < k && p != 0; i++) begin
                p = next_index[p];
            end
            return node_value[p];
        endfunction

        function status_t insert_value(val_t key, val_t value);
            idx_t at    = '0;
            idx_t p     = list_head;
            idx_t fresh;
            int   steps = 0;
            while (p != 0 && steps < NODE_COUNT && at == 0) begin
                if (node_value[p] == key) begin
                    at = p;
                end else begin
                    p = next_index[p];
                    steps++;
                end
            end
            if (free_head == 0) begin
                return STATUS_OVERFLOW;
            end
            fresh             = free_head;
            free_head         = next_index[fresh];
            node_value[fresh] = value;
            if (at == 0) begin
                next_index[fresh] = list_head;
                list_head         = fresh;
            end else begin
                next_index[fresh] = next_index[at];
                next_index[at]    = fresh;
            end
            return STATUS_OK;
        endfunction

        function status_t delete_value(val_t key);
            idx_t prev  = '0;
            idx_t p     = list_head;
            int   steps = 0;
            while (p != 0 && steps < NODE_COUNT) begin
                if (node_value[p] == key) begin
                    if (prev == 0) begin
                        list_head = next_index[p];
                    end else begin
                        next_index[prev] = next_index[p];
                    end
                    // freed node goes to the front of the free chain
                    next_index[p] = free_head;
                    free_head     = p;
                    return STATUS_OK;
                end
                prev = p;
                p    = next_index[p];
                steps++;
            end
            return STATUS_NOT_FOUND;
        endfunction

        function void walk_list();
            list_result_t r;
            idx_t         p = list_head;
            idx_t         nx;
            int           n = 0;
            if (p == 0) begin
                r.item_value = '0;
                r.status     = STATUS_EMPTY;
                r.last       = 1'b1;
                expected_results.push_back(r);
                return;
            end
            while (p != 0 && n < NODE_COUNT) begin
                nx           = next_index[p];
                r.item_value = node_value[p];
                r.status     = STATUS_OK;
                r.last       = (nx == 0) || (n + 1 >= NODE_COUNT);
                expected_results.push_back(r);
                n++;
                p = nx;
            end
        endfunction

        function void push_status(status_t status);
            list_result_t r;
            r.item_value = '0;
            r.status     = status;
            r.last       = 1'b1;
            expected_results.push_back(r);
        endfunction

        function void note_request(mode_t mode, val_t key, val_t value);
            case (mode)
                MODE_INSERT:   push_status(insert_value(key, value));
                MODE_DELETE:   push_status(delete_value(key));
                MODE_TRAVERSE: walk_list();
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_response(val_t item_value, status_t status, logic last);
            list_result_t wanted;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction value=%0d status=%0d last=%0b",
                                          item_value, status, last));
                return;
            end
            wanted = expected_results.pop_front();
            if (item_value !== wanted.item_value) begin
                report_mismatch($sformatf("item_value %0d, wanted %0d",
                                          item_value, wanted.item_value));
            end
            if (status !== wanted.status) begin
                report_mismatch($sformatf("status %0d, wanted %0d", status, wanted.status));
            end
            if (last !== wanted.last) begin
                report_mismatch($sformatf("last %0b, wanted %0b", last, wanted.last));
            end
        endtask
    endclass

    logic    aclk         = 1'b0;
    logic    aresetn      = 1'b0;
    logic    s_valid      = 1'b0;
    logic    s_ready;
    mode_t   s_mode       = MODE_INSERT;
    val_t    s_search_key = '0;
    val_t    s_new_value  = '0;
    logic    m_valid;
    logic    m_ready      = 1'b0;
    val_t    m_item_value;
    status_t m_status;
    logic    m_last;

    list_scoreboard sb;
    int             cycle_count = 0;
    int             calm_left   = 0;
    bit             hold_off_go = 1'b0;
    bit             drain       = 1'b0;

    pooled_linked_list_engine_unit #(
        .NODE_COUNT(NODE_COUNT)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_search_key(s_search_key),
        .s_new_value (s_new_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item_value(m_item_value),
        .m_status    (m_status),
        .m_last      (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic val_t random_value();
        case ($urandom_range(0, 3))
            0: return val_t'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0:       return VAL_MAX;
                    1:       return VAL_MIN;
                    2:       return VAL_ONES;
                    default: return VAL_ZERO;
                endcase
            end
            // narrow range so that keys hit stored values and duplicates appear
            default: return val_t'($urandom_range(0, 15)) - val_t'(8);
        endcase
    endfunction

    function automatic val_t pick_key(int pct_listed);
        int len = sb.list_length();
        if (len > 0 && $urandom_range(0, 99) < pct_listed) begin
            return sb.value_at($urandom_range(0, len - 1));
        end
        return random_value();
    endfunction

    function automatic int sender_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 19);
        if (r == 0) begin
            calm_left = 15;
            return 0;
        end
        if (r < 9) begin
            return 0;
        end
        if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic int stall_len();
        if ($urandom_range(0, 15) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    task automatic send_item(mode_t mode, val_t key, val_t value);
        int gap;
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_search_key <= key;
        s_new_value  <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(mode, key, value);
        gap = sender_gap();
        // valid stays up across back-to-back transactions
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random(int pct_insert, int pct_delete, int pct_traverse);
        int r = $urandom_range(0, 99);
        if (r < pct_insert) begin
            send_item(MODE_INSERT, pick_key(50), random_value());
        end else if (r < pct_insert + pct_delete) begin
            send_item(MODE_DELETE, pick_key(70), random_value());
        end else if (r < pct_insert + pct_delete + pct_traverse) begin
            send_item(MODE_TRAVERSE, random_value(), random_value());
        end else begin
            send_item(MODE_UNUSED, random_value(), random_value());
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_response(m_item_value, m_status, m_last);
        end
    end

    initial begin : ready_driver
        bit hold_done;
        bit level;
        int len;
        hold_done = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (drain) begin
                level = 1'b1;
                len   = 1;
            end else if (hold_off_go && !hold_done) begin
                // long hold-off so the engine backs up into s_ready
                level     = 1'b0;
                len       = HOLD_CYCLES;
                hold_done = 1'b1;
            end else if ($urandom_range(0, 99) < 70) begin
                level = 1'b1;
                len   = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 8);
            end else begin
                level = 1'b0;
                len   = stall_len();
            end
            m_ready <= level;
            for (int n = 0; n < len; n++) begin
                @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int overflows;
        int fill_items;
        sb         = new();
        overflows  = 0;
        fill_items = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list corner cases and an ignored opcode
        send_item(MODE_TRAVERSE, VAL_ZERO, VAL_ZERO);
        send_item(MODE_DELETE, VAL_ZERO, VAL_MAX);
        send_item(MODE_UNUSED, VAL_MAX, VAL_MIN);
        // build: head inserts, insert after head, after tail, after middle
        send_item(MODE_INSERT, VAL_ZERO, VAL_MAX);
        send_item(MODE_INSERT, 32'sd1234, VAL_MIN);
        send_item(MODE_INSERT, VAL_MAX, VAL_ZERO);
        send_item(MODE_INSERT, VAL_MIN, VAL_ONES);
        send_item(MODE_INSERT, VAL_ONES, 32'sd5);
        send_item(MODE_INSERT, VAL_ZERO, 32'sd5);
        send_item(MODE_TRAVERSE, VAL_ONES, VAL_ONES);
        // first of duplicates, head, tail, miss
        send_item(MODE_DELETE, 32'sd5, VAL_ZERO);
        send_item(MODE_DELETE, VAL_MIN, VAL_ZERO);
        send_item(MODE_DELETE, 32'sd5, VAL_ZERO);
        send_item(MODE_DELETE, 32'sd42, VAL_ZERO);
        send_item(MODE_TRAVERSE, VAL_ZERO, VAL_ZERO);
        send_item(MODE_UNUSED, VAL_ONES, VAL_ONES);
        send_item(MODE_DELETE, VAL_ZERO, VAL_ONES);
        send_item(MODE_DELETE, VAL_ONES, VAL_ZERO);
        send_item(MODE_DELETE, VAL_MAX, VAL_ZERO);
        send_item(MODE_TRAVERSE, VAL_ZERO, VAL_ZERO);
        send_item(MODE_INSERT, 32'sh5555_5555, 32'shaaaa_aaaa);
        send_item(MODE_INSERT, 32'shaaaa_aaaa, 32'sh5555_5555);
        send_item(MODE_TRAVERSE, VAL_ZERO, VAL_ZERO);

        // fill the pool, then push against the full pool a few times
        while (overflows < 3 && fill_items < FILL_ITEM_CAP) begin
            if (sb.pool_full()) begin
                send_item(MODE_INSERT, pick_key(50), random_value());
                overflows++;
            end else begin
                send_random(88, 4, 5);
            end
            fill_items++;
        end

        hold_off_go = 1'b1;
        send_item(MODE_TRAVERSE, random_value(), random_value());
        repeat (CHURN_ITEMS) send_random(35, 40, 18);

        s_valid <= 1'b0;
        drain = 1'b1;
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/plle_pkg.sv
src/plle_ram.sv
src/plle_link_store.sv
src/pooled_linked_list_engine_unit.sv
dv/tb_top.sv
